>>> rtl/core/mcfe_pkg.sv
// Shared constants, register codes and divider pipeline types for the command frame encoder.
`timescale 1ns / 1ps

package mcfe_pkg;

  localparam int unsigned DataW         = 32;
  localparam int unsigned LimitW        = 31;
  localparam int unsigned IdW           = 8;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned CfgIndexW     = 3;
  localparam int unsigned PosCodeBits   = 16;
  localparam int unsigned OtherCodeBits = 12;

  // Quotient width of each lane's divider; covers the widest code.
  localparam int unsigned QuoBits         = 16;
  localparam int unsigned DivBitsPerStage = 2;
  localparam int unsigned DivStages       = QuoBits / DivBitsPerStage;
  localparam int unsigned ProdW           = DataW + QuoBits;

  localparam logic [IdW-1:0]    ResetControllerId  = IdW'(1);
  localparam logic [LimitW-1:0] ResetPositionLimit = LimitW'(819200);
  localparam logic [LimitW-1:0] ResetVelocityLimit = LimitW'(1966080);
  localparam logic [LimitW-1:0] ResetTorqueLimit   = LimitW'(655360);
  localparam logic [LimitW-1:0] ResetStiffLimit    = LimitW'(32768000);
  localparam logic [LimitW-1:0] ResetDampLimit     = LimitW'(327680);

  typedef enum logic [CfgIndexW-1:0] {
    CfgControllerId   = 3'd0,
    CfgPositionLimit  = 3'd1,
    CfgVelocityLimit  = 3'd2,
    CfgTorqueLimit    = 3'd3,
    CfgStiffnessLimit = 3'd4,
    CfgDampingLimit   = 3'd5
  } cfg_reg_e;

  // One slot of the restoring divider pipeline.
  typedef struct packed {
    logic               zero;
    logic [DataW-1:0]   span;
    logic [DataW-1:0]   rem;
    logic [QuoBits-1:0] num;
    logic [QuoBits-1:0] quo;
  } div_t;

endpackage

>>> rtl/core/mcfe_div_stage.sv
// One registered step of the restoring divider: two quotient bits per stage.
`timescale 1ns / 1ps

module mcfe_div_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  mcfe_pkg::div_t     data_i,
  output logic               valid_o,
  output mcfe_pkg::div_t     data_o
);

  mcfe_pkg::div_t                data_d;
  mcfe_pkg::div_t                data_q;
  logic                          valid_q;
  logic [mcfe_pkg::DataW:0]      trial;
  logic [mcfe_pkg::DataW:0]      span_ext;
  logic                          qbit;

  always_comb begin
    data_d   = data_i;
    span_ext = {1'b0, data_i.span};
    trial    = '0;
    qbit     = 1'b0;
    for (int k = 0; k < mcfe_pkg::DivBitsPerStage; k++) begin
      // shift in the next numerator bit, subtract the divisor if it fits
      trial = {data_d.rem, data_d.num[mcfe_pkg::QuoBits-1]};
      if (trial >= span_ext) begin
        qbit       = 1'b1;
        data_d.rem = mcfe_pkg::DataW'(trial - span_ext);
      end else begin
        qbit       = 1'b0;
        data_d.rem = trial[mcfe_pkg::DataW-1:0];
      end
      data_d.num = {data_d.num[mcfe_pkg::QuoBits-2:0], 1'b0};
      data_d.quo = {data_d.quo[mcfe_pkg::QuoBits-2:0], qbit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/core/mcfe_lane.sv
// One scaling lane: clamp, offset, multiply by the code range and divide by the span.
`timescale 1ns / 1ps

module mcfe_lane #(
  parameter int unsigned CodeBits  = mcfe_pkg::PosCodeBits,
  parameter bit          Symmetric = 1'b1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [mcfe_pkg::DataW-1:0] x_i,
  input  logic [mcfe_pkg::LimitW-1:0]       limit_i,
  output logic                              valid_o,
  output logic [CodeBits-1:0]               code_o
);

  localparam int unsigned DataW   = mcfe_pkg::DataW;
  localparam int unsigned QuoBits = mcfe_pkg::QuoBits;
  localparam int unsigned ProdW   = mcfe_pkg::ProdW;
  localparam logic [QuoBits-1:0] Full = QuoBits'((32'd1 << CodeBits) - 32'd1);

  logic signed [DataW:0] lim_ext;
  logic signed [DataW:0] lo_ext;
  logic signed [DataW:0] span_ext;
  logic signed [DataW:0] diff;
  logic [DataW-1:0]      off_d;

  logic                  v0_q;
  logic [DataW-1:0]      off_q;
  logic [DataW-1:0]      span0_q;
  logic                  zero0_q;

  logic                  v1_q;
  logic [ProdW-1:0]      prod_q;
  logic [DataW-1:0]      span1_q;
  logic                  zero1_q;

  logic                  div_vld [0:mcfe_pkg::DivStages];
  mcfe_pkg::div_t        div_dat [0:mcfe_pkg::DivStages];

  // Clamp and offset in one step: the offset saturates at zero and at the span.
  always_comb begin
    lim_ext  = $signed({2'b00, limit_i});
    lo_ext   = Symmetric ? -lim_ext : '0;
    span_ext = Symmetric ? (lim_ext <<< 1) : lim_ext;
    diff     = $signed({x_i[DataW-1], x_i}) - lo_ext;
    if (diff < 0) begin
      off_d = '0;
    end else if (diff > span_ext) begin
      off_d = span_ext[DataW-1:0];
    end else begin
      off_d = diff[DataW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      off_q   <= off_d;
      span0_q <= span_ext[DataW-1:0];
      zero0_q <= (limit_i == '0);
    end
    if (v0_q) begin
      prod_q  <= ProdW'(off_q) * ProdW'(Full);
      span1_q <= span0_q;
      zero1_q <= zero0_q;
    end
  end

  // Product is below span * 2^QuoBits, so its upper word starts below the span.
  always_comb begin
    div_vld[0]      = v1_q;
    div_dat[0].zero = zero1_q;
    div_dat[0].span = span1_q;
    div_dat[0].rem  = prod_q[ProdW-1:QuoBits];
    div_dat[0].num  = prod_q[QuoBits-1:0];
    div_dat[0].quo  = '0;
  end

  for (genvar s = 0; s < mcfe_pkg::DivStages; s++) begin : g_div
    mcfe_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_vld[s]),
      .data_i  (div_dat[s]),
      .valid_o (div_vld[s+1]),
      .data_o  (div_dat[s+1])
    );
  end

  // A zero limit collapses the range to one point: force the code to zero.
  assign valid_o = div_vld[mcfe_pkg::DivStages];
  assign code_o  = div_dat[mcfe_pkg::DivStages].zero ? '0
                 : div_dat[mcfe_pkg::DivStages].quo[CodeBits-1:0];

endmodule

>>> rtl/core/mcfe_pack.sv
// Merge stage: pack the five lane codes and the identifier into the frame registers.
`timescale 1ns / 1ps

module mcfe_pack (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic [mcfe_pkg::IdW-1:0]            id_i,
  input  logic [mcfe_pkg::PosCodeBits-1:0]    pos_i,
  input  logic [mcfe_pkg::OtherCodeBits-1:0]  vel_i,
  input  logic [mcfe_pkg::OtherCodeBits-1:0]  kp_i,
  input  logic [mcfe_pkg::OtherCodeBits-1:0]  kd_i,
  input  logic [mcfe_pkg::OtherCodeBits-1:0]  tq_i,
  output logic                                valid_o,
  output logic [mcfe_pkg::IdW-1:0]            frame_id_o,
  output logic [mcfe_pkg::ByteW-1:0]          frame_byte0_o,
  output logic [mcfe_pkg::ByteW-1:0]          frame_byte1_o,
  output logic [mcfe_pkg::ByteW-1:0]          frame_byte2_o,
  output logic [mcfe_pkg::ByteW-1:0]          frame_byte3_o,
  output logic [mcfe_pkg::ByteW-1:0]          frame_byte4_o,
  output logic [mcfe_pkg::ByteW-1:0]          frame_byte5_o,
  output logic [mcfe_pkg::ByteW-1:0]          frame_byte6_o,
  output logic [mcfe_pkg::ByteW-1:0]          frame_byte7_o
);

  logic                         valid_q;
  logic [mcfe_pkg::IdW-1:0]     id_q;
  logic [mcfe_pkg::ByteW-1:0]   byte_q [0:7];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      id_q      <= id_i;
      byte_q[0] <= pos_i[15:8];
      byte_q[1] <= pos_i[7:0];
      byte_q[2] <= vel_i[11:4];
      byte_q[3] <= {vel_i[3:0], kp_i[11:8]};
      byte_q[4] <= kp_i[7:0];
      byte_q[5] <= kd_i[11:4];
      byte_q[6] <= {kd_i[3:0], tq_i[11:8]};
      byte_q[7] <= tq_i[7:0];
    end
  end

  assign valid_o       = valid_q;
  assign frame_id_o    = id_q;
  assign frame_byte0_o = byte_q[0];
  assign frame_byte1_o = byte_q[1];
  assign frame_byte2_o = byte_q[2];
  assign frame_byte3_o = byte_q[3];
  assign frame_byte4_o = byte_q[4];
  assign frame_byte5_o = byte_q[5];
  assign frame_byte6_o = byte_q[6];
  assign frame_byte7_o = byte_q[7];

endmodule

>>> rtl/core/mit_command_frame_encoder.sv
// Top level of the MIT-mode motor command frame encoder.
//
//   channel   direction  handshake                     payload
//   --------  ---------  ----------------------------  ---------------------------------
//   command   in         start high, busy low          five signed Q16.16 set points
//   config    in         cfg_valid_i and cfg_ready_o   cfg_index_i, cfg_data_i
//   frame     out        result_valid_o, one cycle     frame_id_o, frame_byte0..7_o
//
// Five lanes run side by side, one per command value, each a pipeline of clamp/offset,
// a 32x16 multiply and an eight-stage restoring divider (two quotient bits per stage).
// A command is taken every cycle while busy is low; it passes the offset, product,
// divider and pack registers. busy is high in reset and the first cycle after release.
// Reset is asynchronous, active low, and loads the register defaults.
// The receiver cannot stall: each frame is shown for exactly one cycle.
`timescale 1ns / 1ps

module mit_command_frame_encoder (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [mcfe_pkg::DataW-1:0]  target_position_i,
  input  logic signed [mcfe_pkg::DataW-1:0]  target_velocity_i,
  input  logic signed [mcfe_pkg::DataW-1:0]  stiffness_gain_i,
  input  logic signed [mcfe_pkg::DataW-1:0]  damping_gain_i,
  input  logic signed [mcfe_pkg::DataW-1:0]  feedforward_torque_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mcfe_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [mcfe_pkg::DataW-1:0]         cfg_data_i,
  output logic                               result_valid_o,
  output logic [mcfe_pkg::IdW-1:0]           frame_id_o,
  output logic [mcfe_pkg::ByteW-1:0]         frame_byte0_o,
  output logic [mcfe_pkg::ByteW-1:0]         frame_byte1_o,
  output logic [mcfe_pkg::ByteW-1:0]         frame_byte2_o,
  output logic [mcfe_pkg::ByteW-1:0]         frame_byte3_o,
  output logic [mcfe_pkg::ByteW-1:0]         frame_byte4_o,
  output logic [mcfe_pkg::ByteW-1:0]         frame_byte5_o,
  output logic [mcfe_pkg::ByteW-1:0]         frame_byte6_o,
  output logic [mcfe_pkg::ByteW-1:0]         frame_byte7_o
);

  logic                                busy_q;
  logic                                accept;
  logic                                cfg_we;

  logic [mcfe_pkg::IdW-1:0]            ctrl_id_q;
  logic [mcfe_pkg::LimitW-1:0]         pos_lim_q;
  logic [mcfe_pkg::LimitW-1:0]         vel_lim_q;
  logic [mcfe_pkg::LimitW-1:0]         tq_lim_q;
  logic [mcfe_pkg::LimitW-1:0]         kp_lim_q;
  logic [mcfe_pkg::LimitW-1:0]         kd_lim_q;

  logic                                pos_vld;
  logic                                vel_vld;
  logic                                kp_vld;
  logic                                kd_vld;
  logic                                tq_vld;
  logic [mcfe_pkg::PosCodeBits-1:0]    pos_code;
  logic [mcfe_pkg::OtherCodeBits-1:0]  vel_code;
  logic [mcfe_pkg::OtherCodeBits-1:0]  kp_code;
  logic [mcfe_pkg::OtherCodeBits-1:0]  kd_code;
  logic [mcfe_pkg::OtherCodeBits-1:0]  tq_code;
  logic                                lanes_vld;

  // Hold busy for the first cycle out of reset, then take a command every cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy        = busy_q;
  assign accept      = start && !busy_q;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Register file: drop bits above each register's width, ignore unknown indexes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_id_q <= mcfe_pkg::ResetControllerId;
      pos_lim_q <= mcfe_pkg::ResetPositionLimit;
      vel_lim_q <= mcfe_pkg::ResetVelocityLimit;
      tq_lim_q  <= mcfe_pkg::ResetTorqueLimit;
      kp_lim_q  <= mcfe_pkg::ResetStiffLimit;
      kd_lim_q  <= mcfe_pkg::ResetDampLimit;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        mcfe_pkg::CfgControllerId:   ctrl_id_q <= cfg_data_i[mcfe_pkg::IdW-1:0];
        mcfe_pkg::CfgPositionLimit:  pos_lim_q <= cfg_data_i[mcfe_pkg::LimitW-1:0];
        mcfe_pkg::CfgVelocityLimit:  vel_lim_q <= cfg_data_i[mcfe_pkg::LimitW-1:0];
        mcfe_pkg::CfgTorqueLimit:    tq_lim_q  <= cfg_data_i[mcfe_pkg::LimitW-1:0];
        mcfe_pkg::CfgStiffnessLimit: kp_lim_q  <= cfg_data_i[mcfe_pkg::LimitW-1:0];
        mcfe_pkg::CfgDampingLimit:   kd_lim_q  <= cfg_data_i[mcfe_pkg::LimitW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Position, velocity and torque use a symmetric range; the gains start at zero.
  mcfe_lane #(
    .CodeBits  (mcfe_pkg::PosCodeBits),
    .Symmetric (1'b1)
  ) u_lane_pos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .x_i     (target_position_i),
    .limit_i (pos_lim_q),
    .valid_o (pos_vld),
    .code_o  (pos_code)
  );

  mcfe_lane #(
    .CodeBits  (mcfe_pkg::OtherCodeBits),
    .Symmetric (1'b1)
  ) u_lane_vel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .x_i     (target_velocity_i),
    .limit_i (vel_lim_q),
    .valid_o (vel_vld),
    .code_o  (vel_code)
  );

  mcfe_lane #(
    .CodeBits  (mcfe_pkg::OtherCodeBits),
    .Symmetric (1'b0)
  ) u_lane_kp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .x_i     (stiffness_gain_i),
    .limit_i (kp_lim_q),
    .valid_o (kp_vld),
    .code_o  (kp_code)
  );

  mcfe_lane #(
    .CodeBits  (mcfe_pkg::OtherCodeBits),
    .Symmetric (1'b0)
  ) u_lane_kd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .x_i     (damping_gain_i),
    .limit_i (kd_lim_q),
    .valid_o (kd_vld),
    .code_o  (kd_code)
  );

  mcfe_lane #(
    .CodeBits  (mcfe_pkg::OtherCodeBits),
    .Symmetric (1'b1)
  ) u_lane_tq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .x_i     (feedforward_torque_i),
    .limit_i (tq_lim_q),
    .valid_o (tq_vld),
    .code_o  (tq_code)
  );

  // All lanes share one latency, so their valids move in lockstep.
  assign lanes_vld = pos_vld && vel_vld && kp_vld && kd_vld && tq_vld;

  mcfe_pack u_pack (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (lanes_vld),
    .id_i          (ctrl_id_q),
    .pos_i         (pos_code),
    .vel_i         (vel_code),
    .kp_i          (kp_code),
    .kd_i          (kd_code),
    .tq_i          (tq_code),
    .valid_o       (result_valid_o),
    .frame_id_o    (frame_id_o),
    .frame_byte0_o (frame_byte0_o),
    .frame_byte1_o (frame_byte1_o),
    .frame_byte2_o (frame_byte2_o),
    .frame_byte3_o (frame_byte3_o),
    .frame_byte4_o (frame_byte4_o),
    .frame_byte5_o (frame_byte5_o),
    .frame_byte6_o (frame_byte6_o),
    .frame_byte7_o (frame_byte7_o)
  );

endmodule

>>> test/mcfe_frame_checker.sv
// Frame checker for the command frame encoder: mirrors the registers, predicts and compares frames.
`timescale 1ns / 1ps

module mcfe_frame_checker
  import mcfe_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cmd_start_i,
  input  logic                    cmd_busy_i,
  input  logic signed [DataW-1:0] position_i,
  input  logic signed [DataW-1:0] velocity_i,
  input  logic signed [DataW-1:0] stiffness_i,
  input  logic signed [DataW-1:0] damping_i,
  input  logic signed [DataW-1:0] torque_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CfgIndexW-1:0]    cfg_index_i,
  input  logic [DataW-1:0]        cfg_data_i,
  input  logic                    frame_valid_i,
  input  logic [IdW-1:0]          frame_id_i,
  input  logic [7:0][ByteW-1:0]   frame_bytes_i,
  output int unsigned             mismatch_count_o,
  output int unsigned             frames_due_o
);

  typedef struct packed {
    logic [IdW-1:0]        id;
    logic [7:0][ByteW-1:0] bytes;
  } frame_t;

  frame_t expected_frames[$];

  logic [IdW-1:0]    ctrl_id;
  logic [LimitW-1:0] pos_lim;
  logic [LimitW-1:0] vel_lim;
  logic [LimitW-1:0] trq_lim;
  logic [LimitW-1:0] kp_lim;
  logic [LimitW-1:0] kd_lim;

  // Clamp to lo..hi, then scale the offset onto a code of the given width.
  function automatic logic [QuoBits-1:0] scale_code(longint x, longint lo, longint hi,
                                                    int unsigned bits);
    longint unsigned span;
    longint unsigned offset;
    longint unsigned full;
    if (x < lo) x = lo;
    if (x > hi) x = hi;
    span = longint'(hi - lo);
    if (span == 0) return '0;
    offset = longint'(x - lo);
    full   = (64'd1 << bits) - 64'd1;
    return QuoBits'((offset * full) / span);
  endfunction

  function automatic frame_t encode_command();
    logic [QuoBits-1:0] p;
    logic [QuoBits-1:0] v;
    logic [QuoBits-1:0] kp;
    logic [QuoBits-1:0] kd;
    logic [QuoBits-1:0] t;
    frame_t             f;
    p  = scale_code(longint'(position_i), -longint'(pos_lim), longint'(pos_lim), PosCodeBits);
    v  = scale_code(longint'(velocity_i), -longint'(vel_lim), longint'(vel_lim), OtherCodeBits);
    kp = scale_code(longint'(stiffness_i), 0, longint'(kp_lim), OtherCodeBits);
    kd = scale_code(longint'(damping_i), 0, longint'(kd_lim), OtherCodeBits);
    t  = scale_code(longint'(torque_i), -longint'(trq_lim), longint'(trq_lim), OtherCodeBits);
    f.id       = ctrl_id;
    f.bytes[0] = p[15:8];
    f.bytes[1] = p[7:0];
    f.bytes[2] = v[11:4];
    f.bytes[3] = {v[3:0], kp[11:8]};
    f.bytes[4] = kp[7:0];
    f.bytes[5] = kd[11:4];
    f.bytes[6] = {kd[3:0], t[11:8]};
    f.bytes[7] = t[7:0];
    return f;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    frame_t      want;
    int unsigned errs;
    errs = 0;
    if (!rst_ni) begin
      ctrl_id <= ResetControllerId;
      pos_lim <= ResetPositionLimit;
      vel_lim <= ResetVelocityLimit;
      trq_lim <= ResetTorqueLimit;
      kp_lim  <= ResetStiffLimit;
      kd_lim  <= ResetDampLimit;
      expected_frames.delete();
      mismatch_count_o <= 0;
      frames_due_o     <= 0;
    end else begin
      // Retire the frame first, then queue the command taken on this edge.
      if (frame_valid_i) begin
        if (expected_frames.size() == 0) begin
          $error("frame: unexpected frame with id %0d", frame_id_i);
          errs++;
        end else begin
          want = expected_frames.pop_front();
          if (frame_id_i !== want.id) begin
            $error("frame_id: expected %0d, actual %0d", want.id, frame_id_i);
            errs++;
          end
          for (int i = 0; i < 8; i++) begin
            if (frame_bytes_i[i] !== want.bytes[i]) begin
              $error("frame_byte%0d: expected 0x%02h, actual 0x%02h", i, want.bytes[i],
                     frame_bytes_i[i]);
              errs++;
            end
          end
        end
      end
      if (cmd_start_i && !cmd_busy_i) expected_frames.push_back(encode_command());
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgControllerId:   ctrl_id <= cfg_data_i[IdW-1:0];
          CfgPositionLimit:  pos_lim <= cfg_data_i[LimitW-1:0];
          CfgVelocityLimit:  vel_lim <= cfg_data_i[LimitW-1:0];
          CfgTorqueLimit:    trq_lim <= cfg_data_i[LimitW-1:0];
          CfgStiffnessLimit: kp_lim  <= cfg_data_i[LimitW-1:0];
          CfgDampingLimit:   kd_lim  <= cfg_data_i[LimitW-1:0];
          default: ;
        endcase
      end
      mismatch_count_o <= mismatch_count_o + errs;
      frames_due_o     <= expected_frames.size();
    end
  end

endmodule

>>> test/mit_command_frame_encoder_tb.sv
// Testbench top for the command frame encoder: clock, reset, command and register stimulus, verdict.
`timescale 1ns / 1ps

module mit_command_frame_encoder_tb;
  import mcfe_pkg::*;

  // Spare register indexes: the block must ignore writes to them.
  localparam logic [CfgIndexW-1:0] CfgSpareLow  = 3'd6;
  localparam logic [CfgIndexW-1:0] CfgSpareHigh = 3'd7;

  // Slowest correct run: ~625 commands, each with any random sender gaps before it,
  // ~20 drain pauses and the register transfers. RunLimit is set many times above that.
  localparam int unsigned RunLimit     = 400000;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned PhaseCount   = 12;
  localparam int unsigned PhaseItems   = 50;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                    start = 1'b0;
  logic                    busy;
  logic signed [DataW-1:0] cmd_position  = '0;
  logic signed [DataW-1:0] cmd_velocity  = '0;
  logic signed [DataW-1:0] cmd_stiffness = '0;
  logic signed [DataW-1:0] cmd_damping   = '0;
  logic signed [DataW-1:0] cmd_torque    = '0;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [DataW-1:0]     cfg_data  = '0;

  logic           frame_valid;
  logic [IdW-1:0] frame_id;
  logic [ByteW-1:0] fb0, fb1, fb2, fb3, fb4, fb5, fb6, fb7;

  int unsigned mismatch_count;
  int unsigned frames_due;
  int unsigned cycle_count = 0;

  // Limit register values as last written, used only to aim stimulus at the live ranges.
  longint lim_shadow [8];
  // Set during the stretch where the sender never pauses.
  bit     steady = 1'b0;

  always #2 clk_i = ~clk_i;

  mit_command_frame_encoder DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start                (start),
    .busy                 (busy),
    .target_position_i    (cmd_position),
    .target_velocity_i    (cmd_velocity),
    .stiffness_gain_i     (cmd_stiffness),
    .damping_gain_i       (cmd_damping),
    .feedforward_torque_i (cmd_torque),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready),
    .cfg_index_i          (cfg_index),
    .cfg_data_i           (cfg_data),
    .result_valid_o       (frame_valid),
    .frame_id_o           (frame_id),
    .frame_byte0_o        (fb0),
    .frame_byte1_o        (fb1),
    .frame_byte2_o        (fb2),
    .frame_byte3_o        (fb3),
    .frame_byte4_o        (fb4),
    .frame_byte5_o        (fb5),
    .frame_byte6_o        (fb6),
    .frame_byte7_o        (fb7)
  );

  mcfe_frame_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_start_i      (start),
    .cmd_busy_i       (busy),
    .position_i       (cmd_position),
    .velocity_i       (cmd_velocity),
    .stiffness_i      (cmd_stiffness),
    .damping_i        (cmd_damping),
    .torque_i         (cmd_torque),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .frame_valid_i    (frame_valid),
    .frame_id_i       (frame_id),
    .frame_bytes_i    ({fb7, fb6, fb5, fb4, fb3, fb2, fb1, fb0}),
    .mismatch_count_o (mismatch_count),
    .frames_due_o     (frames_due)
  );

  // Watchdog: a hung handshake or a lost frame ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RunLimit) begin
      $display("mit_command_frame_encoder regression: fail");
      $finish;
    end
  end

  // Present one command and hold it until the start transfer. Pause first at random,
  // unless in the steady stretch. start stays high on return, so back-to-back
  // commands run without a gap.
  task automatic send_command(input logic [DataW-1:0] p, input logic [DataW-1:0] v,
                              input logic [DataW-1:0] kp, input logic [DataW-1:0] kd,
                              input logic [DataW-1:0] t);
    while (!steady && $urandom_range(99) < 22) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start         <= 1'b1;
    cmd_position  <= p;
    cmd_velocity  <= v;
    cmd_stiffness <= kp;
    cmd_damping   <= kd;
    cmd_torque    <= t;
    do @(posedge clk_i); while (busy);
  endtask

  // Drop start and hold until every queued frame has come back. The first edge lets
  // the checker count a command taken on the edge this was called from.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (frames_due != 0);
  endtask

  // One register transfer. cfg_valid stays high so writes can go back to back;
  // close_config drops it afterwards.
  task automatic write_register(input logic [CfgIndexW-1:0] idx, input logic [DataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx >= CfgPositionLimit && idx <= CfgDampingLimit)
      lim_shadow[idx] = longint'({1'b0, data[LimitW-1:0]});
  endtask

  task automatic close_config();
    cfg_valid <= 1'b0;
  endtask

  task automatic set_all_limits(input logic [DataW-1:0] data);
    for (int r = CfgPositionLimit; r <= CfgDampingLimit; r++)
      write_register(CfgIndexW'(r), data);
  endtask

  // Mostly inside lo..hi, sometimes right on or just past an edge, near zero,
  // or anywhere in the 32-bit range.
  function automatic logic [DataW-1:0] pick_value(longint lo, longint hi);
    longint unsigned r;
    longint unsigned width;
    longint          v;
    width = longint'(hi - lo + 1);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: begin
        r = {$urandom, $urandom};
        v = lo + longint'(r % width);
      end
      5:       v = $urandom_range(1) ? hi : lo;
      6:       v = $urandom_range(1) ? hi + 1 : lo - 1;
      7:       v = longint'($urandom_range(64)) - 32;
      default: v = longint'($signed($urandom));
    endcase
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return DataW'(v);
  endfunction

  function automatic logic [DataW-1:0] pick_limit();
    case ($urandom_range(5))
      0:       return $urandom;
      1:       return $urandom_range(1000, 1);
      2:       return $urandom_range(32'h0100_0000, 32'h0001_0000);
      3: begin
        case ($urandom_range(3))
          0:       return 32'h0000_0000;
          1:       return 32'h0000_0001;
          2:       return 32'h7FFF_FFFF;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom_range(32'h0400_0000, 1);
    endcase
  endfunction

  initial begin : stimulus
    longint pl, vl, tl, kl, dl;
    lim_shadow = '{default: 0};
    lim_shadow[CfgPositionLimit]  = longint'(ResetPositionLimit);
    lim_shadow[CfgVelocityLimit]  = longint'(ResetVelocityLimit);
    lim_shadow[CfgTorqueLimit]    = longint'(ResetTorqueLimit);
    lim_shadow[CfgStiffnessLimit] = longint'(ResetStiffLimit);
    lim_shadow[CfgDampingLimit]   = longint'(ResetDampLimit);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset ranges first, at zero, the 32-bit extremes and each range edge.
    pl = lim_shadow[CfgPositionLimit];
    vl = lim_shadow[CfgVelocityLimit];
    tl = lim_shadow[CfgTorqueLimit];
    kl = lim_shadow[CfgStiffnessLimit];
    dl = lim_shadow[CfgDampingLimit];
    send_command('0, '0, '0, '0, '0);
    send_command(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_command(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_command(32'(pl), 32'(vl), 32'(kl), 32'(dl), 32'(tl));
    send_command(32'(-pl), 32'(-vl), '0, '0, 32'(-tl));
    send_command(32'(pl + 1), 32'(-vl - 1), 32'(kl + 1), 32'hFFFF_FFFF, 32'(tl + 1));
    send_command(32'(pl - 1), 32'(-vl + 1), 32'd1, 32'(dl - 1), 32'(-tl + 1));
    send_command(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(32'd1, 32'd1, 32'd1, 32'd1, 32'd1);
    send_command(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);

    // Widest ranges and the top identifier.
    wait_drained();
    write_register(CfgControllerId, 32'h0000_00FF);
    set_all_limits(32'h7FFF_FFFF);
    close_config();
    send_command(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_command(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_command('0, '0, '0, '0, '0);
    send_command(32'h8000_0001, 32'h8000_0001, 32'h0000_0001, 32'h7FFF_FFFE, 32'h8000_0001);

    // Narrowest nonzero ranges and identifier zero.
    wait_drained();
    write_register(CfgControllerId, 32'h0000_0000);
    set_all_limits(32'h0000_0001);
    close_config();
    send_command('0, '0, '0, '0, '0);
    send_command(32'd1, 32'd1, 32'd1, 32'd1, 32'd1);
    send_command(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(32'd2, 32'hFFFF_FFFE, 32'd2, 32'd0, 32'hFFFF_FFFE);

    // Zero limits collapse every range to a point: all codes must read zero.
    wait_drained();
    write_register(CfgControllerId, 32'h0000_005A);
    set_all_limits(32'h0000_0000);
    close_config();
    send_command(32'h1234_5678, 32'hEDCB_A987, 32'h0000_0100, 32'hFFFF_0000, 32'h0000_0001);
    send_command(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_command(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);

    // Bits above each register's width are dropped; spare indexes change nothing.
    wait_drained();
    write_register(CfgControllerId, 32'hFFFF_12C3);
    set_all_limits(32'h8000_03E8);
    write_register(CfgSpareLow, 32'h0000_0007);
    write_register(CfgSpareHigh, 32'hFFFF_FFFF);
    close_config();
    send_command(32'd1000, 32'hFFFF_FC18, 32'd1000, 32'd500, 32'd0);
    send_command(32'd999, 32'hFFFF_FC19, 32'd1, 32'd1001, 32'hFFFF_FC17);
    send_command(32'd3, 32'hFFFF_FFFD, 32'd7, 32'd250, 32'd333);

    // Random phases: a fresh register setting per phase, then a burst of commands.
    for (int ph = 0; ph < PhaseCount; ph++) begin
      wait_drained();
      for (int r = CfgControllerId; r <= CfgDampingLimit; r++) begin
        if (ph == 0 || $urandom_range(99) < 70)
          write_register(CfgIndexW'(r), (r == CfgControllerId) ? $urandom : pick_limit());
      end
      if ($urandom_range(3) == 0)
        write_register($urandom_range(1) ? CfgSpareLow : CfgSpareHigh, $urandom);
      close_config();
      // One long stretch where the sender never pauses.
      steady = (ph == 4);
      for (int n = 0; n < PhaseItems; n++) begin
        // Once, hold off mid-burst until the pipeline has emptied.
        if (ph == 7 && n == PhaseItems / 2) wait_drained();
        pl = lim_shadow[CfgPositionLimit];
        vl = lim_shadow[CfgVelocityLimit];
        tl = lim_shadow[CfgTorqueLimit];
        kl = lim_shadow[CfgStiffnessLimit];
        dl = lim_shadow[CfgDampingLimit];
        if ($urandom_range(99) < 15)
          send_command($urandom, $urandom, $urandom, $urandom, $urandom);
        else
          send_command(pick_value(-pl, pl), pick_value(-vl, vl), pick_value(0, kl),
                       pick_value(0, dl), pick_value(-tl, tl));
      end
    end
    steady = 1'b0;

    // Let the last frames out, then leave room for any stray frame to show up.
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0 && frames_due == 0)
      $display("mit_command_frame_encoder regression: pass");
    else
      $display("mit_command_frame_encoder regression: fail");
    $finish;
  end

endmodule

>>> mit_command_frame_encoder.f
rtl/core/mcfe_pkg.sv
rtl/core/mcfe_div_stage.sv
rtl/core/mcfe_lane.sv
rtl/core/mcfe_pack.sv
rtl/core/mit_command_frame_encoder.sv
test/mcfe_frame_checker.sv
test/mit_command_frame_encoder_tb.sv
